[src/cbt_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and bernstein weight table of the bezier tessellator
package cbt_pkg;

   localparam int COORD_WIDTH  = 24;
   localparam int SAMPLES      = 20;
   localparam int SAMPLE_WIDTH = $clog2(SAMPLES);
   localparam int DEN          = SAMPLES * SAMPLES * SAMPLES;
   localparam int WEIGHT_WIDTH = $clog2(DEN + 1);
   localparam int ACC_WIDTH    = COORD_WIDTH + WEIGHT_WIDTH + 1;

   // den = 2^DEN_SHIFT * 125, the odd part is divided by a reciprocal multiply
   localparam int DEN_SHIFT    = 6;
   localparam int QIN_WIDTH    = ACC_WIDTH - 1 - DEN_SHIFT;
   localparam int RECIP_WIDTH  = 32;
   localparam int RECIP_SHIFT  = 38;
   localparam int MUL_WIDTH    = QIN_WIDTH + RECIP_WIDTH;
   localparam int QUOT_WIDTH   = COORD_WIDTH + 1;
   localparam logic [RECIP_WIDTH-1:0] RECIP = 32'd2199023256;

   // half den for rounding plus den * 2^(w-1) to keep the sum non-negative
   localparam longint BIAS_VALUE = longint'(DEN / 2)
                                 + longint'(DEN) * (longint'(1) << (COORD_WIDTH - 1));
   localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS = ACC_WIDTH'(BIAS_VALUE);

   localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};

   localparam int HEAD_DEPTH  = 3;
   localparam int GROUP_DEPTH = 4;
   localparam int COORDS      = 3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [COORDS-1:0][COORD_WIDTH-1:0] point_type;

   typedef struct packed {
      coord_type ctrl_x;
      coord_type ctrl_y;
      coord_type ctrl_z;
      logic      final_point;
   } req_type;

   typedef struct packed {
      coord_type pos_x;
      coord_type pos_y;
      coord_type pos_z;
      logic      segment_end;
      logic      curve_end;
   } rsp_type;

   typedef struct packed {
      logic                    load;
      logic                    head_we;
      logic [1:0]              head_idx;
      logic [1:0]              group_idx;
      logic                    copy;
      logic [1:0]              copy_src;
      logic [1:0]              copy_dst;
      logic                    issue;
      logic [SAMPLE_WIDTH-1:0] sample_idx;
      logic                    seg_end;
      logic                    curve_end;
   } cmd_type;

   typedef struct packed {
      logic advance;
   } status_type;

   typedef logic [GROUP_DEPTH-1:0][WEIGHT_WIDTH-1:0] weight_row_type;
   typedef weight_row_type [SAMPLES-1:0] weight_table_type;

   function automatic weight_table_type build_weights();
      weight_table_type tab;
      int u;
      for (int j = 0; j < SAMPLES; j++) begin
         u = SAMPLES - j;
         tab[j][0] = WEIGHT_WIDTH'(u * u * u);
         tab[j][1] = WEIGHT_WIDTH'(3 * j * u * u);
         tab[j][2] = WEIGHT_WIDTH'(3 * j * j * u);
         tab[j][3] = WEIGHT_WIDTH'(j * j * j);
      end
      return tab;
   endfunction

   localparam weight_table_type WEIGHTS = build_weights();

endpackage

[src/cubic_bezier_tessellator_unit.sv]
`timescale 1ns / 1ps
// top level of the cubic bezier tessellator
//
//   channel  direction  ports                         content
//   req      in         req_valid/req_ready/req_data  one control point and final flag
//   rsp      out        rsp_valid/rsp_ready/rsp_data  one curve sample and end flags
//
// each accepted request stores one point; a full group then issues 20 samples, one per cycle unless the output stalls.
// a partial final group first copies head points into its remaining slots.
// issued samples pass the multiply and sum registers, then the reciprocal, into the output register.
// a group holds four points.
// reset is synchronous; stored points are undefined until written.
// rsp_ready low while the output register holds a sample freezes the sample pipeline and the sample sequencer.
module cubic_bezier_tessellator_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cbt_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cbt_pkg::rsp_type  rsp_data
);
   import cbt_pkg::*;

   cmd_type    cmd;
   status_type status;

   cbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_final (req_data.final_point),
      .status    (status),
      .cmd       (cmd)
   );

   cbt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // no point is taken while samples are being issued
   assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !req_ready)
      else $error("point accepted during sample issue");

   // head copies never overlap point intake or issue
   assert property (@(posedge clock) disable iff (reset)
      cmd.copy |-> (!req_ready && !cmd.issue))
      else $error("group completion overlaps intake or issue");

   // curve end only on a segment's last sample
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.curve_end) |-> rsp_data.segment_end)
      else $error("curve end without segment end");

endmodule

[src/cbt_ctrl.sv]
`timescale 1ns / 1ps
// control state machine: point counting, group completion and sample sequencing
module cbt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_final,
   input  cbt_pkg::status_type  status,
   output cbt_pkg::cmd_type     cmd
);
   import cbt_pkg::*;

   typedef enum logic [2:0] {
      ST_COLLECT = 3'b001,
      ST_FILL    = 3'b010,
      ST_EMIT    = 3'b100
   } ctrl_state_type;

   localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_LAST = SAMPLE_WIDTH'(SAMPLES - 1);

   ctrl_state_type          state_ff, state_in;
   logic [1:0]              fill_ff, fill_in;
   logic [2:0]              seen_ff, seen_in;
   logic [1:0]              copy_k_ff, copy_k_in;
   logic [1:0]              copy_base_ff, copy_base_in;
   logic [2:0]              copy_cnt_ff, copy_cnt_in;
   logic [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic                    last_ff, last_in;

   logic       accept;
   logic [2:0] fill_next;
   logic [2:0] seen_next;
   logic [1:0] src;

   always_comb begin
      req_ready = (state_ff == ST_COLLECT);
      accept    = req_valid && req_ready;
      fill_next = {1'b0, fill_ff} + 3'd1;
      seen_next = (seen_ff == 3'd4) ? seen_ff : seen_ff + 3'd1;

      // wrap onto the curve's first points
      unique case (copy_cnt_ff)
         3'd1: begin
            src = 2'd0;
         end
         3'd2: begin
            src = {1'b0, copy_k_ff[0]};
         end
         3'd3: begin
            src = (copy_k_ff == 2'd3) ? 2'd0 : copy_k_ff;
         end
         default: begin
            src = copy_k_ff - copy_base_ff;
         end
      endcase
   end

   always_comb begin
      cmd.load       = accept;
      cmd.head_we    = (seen_ff < 3'(HEAD_DEPTH));
      cmd.head_idx   = seen_ff[1:0];
      cmd.group_idx  = fill_ff;
      cmd.copy       = (state_ff == ST_FILL);
      cmd.copy_src   = src;
      cmd.copy_dst   = copy_k_ff;
      cmd.issue      = (state_ff == ST_EMIT) && status.advance;
      cmd.sample_idx = sample_ff;
      cmd.seg_end    = (sample_ff == SAMPLE_LAST);
      cmd.curve_end  = last_ff && (sample_ff == SAMPLE_LAST);
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      seen_in      = seen_ff;
      copy_k_in    = copy_k_ff;
      copy_base_in = copy_base_ff;
      copy_cnt_in  = copy_cnt_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (accept) begin
               if (fill_next == 3'd4) begin
                  state_in  = ST_EMIT;
                  sample_in = '0;
                  last_in   = req_final;
                  fill_in   = 2'd0;
                  seen_in   = req_final ? 3'd0 : seen_next;
               end else if (req_final) begin
                  state_in     = ST_FILL;
                  copy_k_in    = fill_next[1:0];
                  copy_base_in = fill_next[1:0];
                  copy_cnt_in  = seen_next;
                  last_in      = 1'b1;
                  fill_in      = 2'd0;
                  seen_in      = 3'd0;
               end else begin
                  fill_in = fill_next[1:0];
                  seen_in = seen_next;
               end
            end
         end
         ST_FILL: begin
            if (copy_k_ff == 2'd3) begin
               state_in  = ST_EMIT;
               sample_in = '0;
            end else begin
               copy_k_in = copy_k_ff + 2'd1;
            end
         end
         ST_EMIT: begin
            if (status.advance) begin
               if (sample_ff == SAMPLE_LAST) begin
                  state_in = ST_COLLECT;
               end else begin
                  sample_in = sample_ff + SAMPLE_WIDTH'(1);
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         fill_ff  <= 2'd0;
         seen_ff  <= 3'd0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         seen_ff  <= seen_in;
         last_ff  <= last_in;
      end
      copy_k_ff    <= copy_k_in;
      copy_base_ff <= copy_base_in;
      copy_cnt_ff  <= copy_cnt_in;
      sample_ff    <= sample_in;
   end

endmodule

[src/cbt_datapath.sv]
`timescale 1ns / 1ps
// point storage, weight multiply, rounding divide pipeline and output register
module cbt_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  cbt_pkg::req_type     req_data,
   input  cbt_pkg::cmd_type     cmd,
   output cbt_pkg::status_type  status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cbt_pkg::rsp_type     rsp_data
);
   import cbt_pkg::*;

   point_type head_ff  [HEAD_DEPTH];
   point_type head_in  [HEAD_DEPTH];
   point_type group_ff [GROUP_DEPTH];
   point_type group_in [GROUP_DEPTH];
   point_type point;

   logic                        advance;
   weight_row_type              weight;

   logic                        p1_valid_ff, p1_valid_in;
   logic                        p1_seg_ff, p1_seg_in;
   logic                        p1_curve_ff, p1_curve_in;
   logic signed [ACC_WIDTH-1:0] p1_prod_ff [COORDS][GROUP_DEPTH];
   logic signed [ACC_WIDTH-1:0] p1_prod_in [COORDS][GROUP_DEPTH];

   logic                        p2_valid_ff, p2_valid_in;
   logic                        p2_seg_ff, p2_seg_in;
   logic                        p2_curve_ff, p2_curve_in;
   logic [QIN_WIDTH-1:0]        p2_quo_ff [COORDS];
   logic [QIN_WIDTH-1:0]        p2_quo_in [COORDS];

   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_data_ff, rsp_data_in;

   logic signed [ACC_WIDTH-1:0] sum   [COORDS];
   logic [MUL_WIDTH-1:0]        recip [COORDS];
   logic [QUOT_WIDTH-1:0]       quot  [COORDS];
   logic [COORD_WIDTH-1:0]      coord [COORDS];

   always_comb begin
      point = {req_data.ctrl_z, req_data.ctrl_y, req_data.ctrl_x};
      for (int i = 0; i < HEAD_DEPTH; i++) begin
         head_in[i] = head_ff[i];
      end
      for (int i = 0; i < GROUP_DEPTH; i++) begin
         group_in[i] = group_ff[i];
      end
      if (cmd.load) begin
         if (cmd.head_we) begin
            head_in[cmd.head_idx] = point;
         end
         group_in[cmd.group_idx] = point;
      end
      if (cmd.copy) begin
         group_in[cmd.copy_dst] = head_ff[cmd.copy_src];
      end
   end

   always_comb begin
      advance        = !rsp_valid_ff || rsp_ready;
      status.advance = advance;
      weight         = WEIGHTS[cmd.sample_idx];

      p1_valid_in = advance ? cmd.issue : p1_valid_ff;
      p1_seg_in   = advance ? cmd.seg_end : p1_seg_ff;
      p1_curve_in = advance ? cmd.curve_end : p1_curve_ff;
      for (int c = 0; c < COORDS; c++) begin
         for (int k = 0; k < GROUP_DEPTH; k++) begin
            p1_prod_in[c][k] = advance
               ? ACC_WIDTH'($signed(group_ff[k][c]))
                 * $signed(ACC_WIDTH'({1'b0, weight[k]}))
               : p1_prod_ff[c][k];
         end
      end

      // floor((acc + den/2) / den), biased to stay non-negative
      p2_valid_in = advance ? p1_valid_ff : p2_valid_ff;
      p2_seg_in   = advance ? p1_seg_ff : p2_seg_ff;
      p2_curve_in = advance ? p1_curve_ff : p2_curve_ff;
      for (int c = 0; c < COORDS; c++) begin
         sum[c] = p1_prod_ff[c][0] + p1_prod_ff[c][1] + p1_prod_ff[c][2]
                + p1_prod_ff[c][3] + ROUND_BIAS;
         p2_quo_in[c] = advance ? sum[c][DEN_SHIFT +: QIN_WIDTH] : p2_quo_ff[c];
      end

      for (int c = 0; c < COORDS; c++) begin
         recip[c] = MUL_WIDTH'(p2_quo_ff[c]) * MUL_WIDTH'(RECIP);
         quot[c]  = recip[c][RECIP_SHIFT +: QUOT_WIDTH];
         coord[c] = quot[c][COORD_WIDTH]
                  ? COORD_MAX
                  : {~quot[c][COORD_WIDTH-1], quot[c][COORD_WIDTH-2:0]};
      end

      rsp_valid_in = advance ? p2_valid_ff : rsp_valid_ff;
      if (advance) begin
         rsp_data_in.pos_x       = $signed(coord[0]);
         rsp_data_in.pos_y       = $signed(coord[1]);
         rsp_data_in.pos_z       = $signed(coord[2]);
         rsp_data_in.segment_end = p2_seg_ff;
         rsp_data_in.curve_end   = p2_curve_ff;
      end else begin
         rsp_data_in = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      head_ff     <= head_in;
      group_ff    <= group_in;
      p1_seg_ff   <= p1_seg_in;
      p1_curve_ff <= p1_curve_in;
      p1_prod_ff  <= p1_prod_in;
      p2_seg_ff   <= p2_seg_in;
      p2_curve_ff <= p2_curve_in;
      p2_quo_ff   <= p2_quo_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
